FILE: rtl/ppfc_pkg.sv
package ppfc_pkg;

  // Layout codes
  localparam logic [1:0] LAYOUT_555  = 2'd0;
  localparam logic [1:0] LAYOUT_4444 = 2'd1;
  localparam logic [1:0] LAYOUT_8    = 2'd2;
  localparam logic [1:0] LAYOUT_16   = 2'd3;

  // Channel order codes
  localparam logic [1:0] ORDER_RGBA = 2'd0;
  localparam logic [1:0] ORDER_ARGB = 2'd1;
  localparam logic [1:0] ORDER_BGRA = 2'd2;
  localparam logic [1:0] ORDER_ABGR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LAYOUT  = 2'd0;
  localparam logic [1:0] CFG_ORDER   = 2'd1;
  localparam logic [1:0] CFG_PRESENT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [1:0] LAYOUT_RST  = LAYOUT_8;
  localparam logic [1:0] ORDER_RST   = ORDER_RGBA;
  localparam logic [3:0] PRESENT_RST = 4'hF;

  // Component indexes and defaults
  localparam int unsigned COMP_ALPHA = 3;
  localparam logic [15:0] ALPHA_DEFAULT = 16'hFFFF;
  localparam logic [15:0] COLOR_DEFAULT = 16'h0000;

  // Input mode codes
  localparam logic MODE_UNPACK = 1'b0;
  localparam logic MODE_PACK   = 1'b1;

  localparam int unsigned CFG_DW = 4;

  typedef struct packed {
    logic [1:0] layout;
    logic [1:0] order;
    logic [3:0] present;
  } cfg_t;

  // Four UNORM16 components, index 0 red .. 3 alpha
  typedef logic [3:0][15:0] comp4_t;

  // Slot of each component for each channel order: [order][component]
  localparam logic [1:0] SLOT_TAB [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  function automatic logic [1:0] slot_of(input logic [1:0] order, input logic [1:0] comp);
    return SLOT_TAB[order][comp];
  endfunction

endpackage

FILE: rtl/ppfc_if.sv
// Input channel: mode, pixel word and four components
interface ppfc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] pixel_in;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;

  modport source (
    output valid, mode, pixel_in, red_in, green_in, blue_in, alpha_in,
    input  ready
  );
  modport sink (
    input  valid, mode, pixel_in, red_in, green_in, blue_in, alpha_in,
    output ready
  );
endinterface

// Output channel: converted word and four components
interface ppfc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixel_out;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;

  modport source (
    output valid, pixel_out, red_out, green_out, blue_out, alpha_out,
    input  ready
  );
  modport sink (
    input  valid, pixel_out, red_out, green_out, blue_out, alpha_out,
    output ready
  );
endinterface

FILE: rtl/ppfc_unpack.sv
module ppfc_unpack (
  input  ppfc_pkg::cfg_t   cfg_i,
  input  logic [63:0]      pixel_i,
  output ppfc_pkg::comp4_t comp_o
);

  // Extract each component from its slot and expand to UNORM16
  always_comb begin
    logic [1:0]  slot;
    logic [4:0]  v5;
    logic [3:0]  v4;
    logic [7:0]  v8;
    logic [15:0] val;
    for (int k = 0; k < 4; k++) begin
      slot = ppfc_pkg::slot_of(cfg_i.order, 2'(k));
      v5   = '0;
      v4   = pixel_i[{~slot, 2'b00} +: 4];
      v8   = pixel_i[{slot, 3'b000} +: 8];
      case (slot)
        2'd0:    v5 = pixel_i[14:10];
        2'd1:    v5 = pixel_i[9:5];
        2'd2:    v5 = pixel_i[4:0];
        default: v5 = '0;  // slot three does not exist in 5-5-5
      endcase
      case (cfg_i.layout)
        // v*65535/31 rounded: v*2114 plus one when v >= 16
        ppfc_pkg::LAYOUT_555:  val = v5 * 16'd2114 + {15'd0, v5[4]};
        ppfc_pkg::LAYOUT_4444: val = {4{v4}};
        ppfc_pkg::LAYOUT_8:    val = {2{v8}};
        default:               val = pixel_i[{slot, 4'b0000} +: 16];
      endcase
      if (cfg_i.present[k]) begin
        comp_o[k] = val;
      end else if (k == ppfc_pkg::COMP_ALPHA) begin
        comp_o[k] = ppfc_pkg::ALPHA_DEFAULT;
      end else begin
        comp_o[k] = ppfc_pkg::COLOR_DEFAULT;
      end
    end
  end

endmodule

FILE: rtl/ppfc_pack.sv
module ppfc_pack (
  input  ppfc_pkg::cfg_t   cfg_i,
  input  logic [63:0]      pixel_i,
  input  ppfc_pkg::comp4_t comp_i,
  output logic [63:0]      pixel_o
);

  // floor(x / 65535) for x below 256 * 65535: estimate, then one correction
  function automatic logic [7:0] div_65535(input logic [23:0] x);
    logic [7:0]  q0;
    logic [16:0] r;
    q0 = x[23:16];
    r  = {1'b0, x[15:0]} + {9'd0, q0};
    return q0 + {7'd0, (r >= 17'd65535)};
  endfunction

  // Build the field mask and field data of every present component, then merge
  always_comb begin
    logic [1:0]  slot;
    logic [15:0] c;
    logic [23:0] x;
    logic [7:0]  q;
    logic [5:0]  sh;
    logic [63:0] mask;
    logic [63:0] data;
    logic [63:0] mask_acc;
    logic [63:0] data_acc;
    mask_acc = '0;
    data_acc = '0;
    for (int k = 0; k < 4; k++) begin
      slot = ppfc_pkg::slot_of(cfg_i.order, 2'(k));
      // zero alpha clears the color components
      if (k != ppfc_pkg::COMP_ALPHA && comp_i[ppfc_pkg::COMP_ALPHA] == 16'd0) begin
        c = '0;
      end else begin
        c = comp_i[k];
      end
      // c * (2^n - 1) for the field width n
      case (cfg_i.layout)
        ppfc_pkg::LAYOUT_555:  x = {3'd0, c, 5'd0} - {8'd0, c};
        ppfc_pkg::LAYOUT_4444: x = {4'd0, c, 4'd0} - {8'd0, c};
        default:               x = {c, 8'd0} - {8'd0, c};
      endcase
      q = div_65535(x);
      case (cfg_i.layout)
        ppfc_pkg::LAYOUT_555: begin
          case (slot)
            2'd0:    sh = 6'd10;
            2'd1:    sh = 6'd5;
            default: sh = 6'd0;
          endcase
          if (slot == 2'd3) begin
            mask = '0;
            data = '0;
          end else begin
            // field plus the unused top bit
            mask = (64'h1F << sh) | 64'h8000;
            data = {59'd0, q[4:0]} << sh;
          end
        end
        ppfc_pkg::LAYOUT_4444: begin
          sh   = {2'b00, ~slot, 2'b00};
          mask = 64'hF << sh;
          data = {60'd0, q[3:0]} << sh;
        end
        ppfc_pkg::LAYOUT_8: begin
          sh   = {1'b0, slot, 3'b000};
          mask = 64'hFF << sh;
          data = {56'd0, q} << sh;
        end
        default: begin
          sh   = {slot, 4'b0000};
          mask = 64'hFFFF << sh;
          data = {48'd0, c} << sh;
        end
      endcase
      if (cfg_i.present[k]) begin
        mask_acc = mask_acc | mask;
        data_acc = data_acc | data;
      end
    end
    pixel_o = (pixel_i & ~mask_acc) | data_acc;
  end

endmodule

FILE: rtl/packed_pixel_format_converter_unit.sv
// Pipeline: an input transfer is held in the input register, then in the result register,
//   which drives the output. Throughput: one item per cycle unless out_o.ready stalls;
//   the pack and unpack paths sit between the two registers.
// Reset (rst_ni low, asynchronous): both stages empty, layout 8-bit, order RGBA,
//   all four components present.
module packed_pixel_format_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [ppfc_pkg::CFG_DW-1:0]   cfg_data_i,
  ppfc_in_if.sink                       in_i,
  ppfc_out_if.source                    out_o
);

  // Configuration registers
  ppfc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ppfc_pkg::CFG_LAYOUT:  cfg_d.layout  = cfg_data_i[1:0];
        ppfc_pkg::CFG_ORDER:   cfg_d.order   = cfg_data_i[1:0];
        ppfc_pkg::CFG_PRESENT: cfg_d.present = cfg_data_i[3:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout  <= ppfc_pkg::LAYOUT_RST;
      cfg_q.order   <= ppfc_pkg::ORDER_RST;
      cfg_q.present <= ppfc_pkg::PRESENT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline control
  logic s1_vld_q, s1_vld_d;
  logic s2_vld_q, s2_vld_d;
  logic adv2;
  logic in_xfer;

  assign adv2     = !s2_vld_q || out_o.ready;
  assign in_i.ready = !s1_vld_q || adv2;
  assign in_xfer  = in_i.valid && in_i.ready;

  assign s1_vld_d = in_xfer ? 1'b1 : (adv2 ? 1'b0 : s1_vld_q);
  assign s2_vld_d = adv2 ? s1_vld_q : s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  // Input register
  logic             s1_mode_q;
  logic [63:0]      s1_pix_q;
  ppfc_pkg::comp4_t s1_comp_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q <= in_i.mode;
      s1_pix_q  <= in_i.pixel_in;
      s1_comp_q <= {in_i.alpha_in, in_i.blue_in, in_i.green_in, in_i.red_in};
    end
  end

  // Conversion datapath
  ppfc_pkg::comp4_t unpack_comp;
  logic [63:0]      pack_pix;

  ppfc_unpack u_unpack (
    .cfg_i   (cfg_q),
    .pixel_i (s1_pix_q),
    .comp_o  (unpack_comp)
  );

  ppfc_pack u_pack (
    .cfg_i   (cfg_q),
    .pixel_i (s1_pix_q),
    .comp_i  (s1_comp_q),
    .pixel_o (pack_pix)
  );

  // Result register
  logic [63:0]      s2_pix_q, s2_pix_d;
  ppfc_pkg::comp4_t s2_comp_q, s2_comp_d;

  always_comb begin
    if (s1_mode_q == ppfc_pkg::MODE_PACK) begin
      s2_pix_d  = pack_pix;
      s2_comp_d = '0;
    end else begin
      s2_pix_d  = s1_pix_q;
      s2_comp_d = unpack_comp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_vld_q) begin
      s2_pix_q  <= s2_pix_d;
      s2_comp_q <= s2_comp_d;
    end
  end

  assign out_o.valid     = s2_vld_q;
  assign out_o.pixel_out = s2_pix_q;
  assign out_o.red_out   = s2_comp_q[0];
  assign out_o.green_out = s2_comp_q[1];
  assign out_o.blue_out  = s2_comp_q[2];
  assign out_o.alpha_out = s2_comp_q[3];

`ifndef SYNTHESIS
  // An item in the input register that advances reaches the result register
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && adv2) |=> s2_vld_q)
    else $error("item lost between input and result register");

  // Pack results carry zero components
  a_pack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && adv2 && s1_mode_q == ppfc_pkg::MODE_PACK) |=>
      (out_o.red_out == 16'd0 && out_o.green_out == 16'd0 &&
       out_o.blue_out == 16'd0 && out_o.alpha_out == 16'd0))
    else $error("pack result with nonzero components");

  // Unpack results pass the word through unchanged
  a_unpack_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && adv2 && s1_mode_q == ppfc_pkg::MODE_UNPACK) |=>
      (out_o.pixel_out == $past(s1_pix_q)))
    else $error("unpack result changed the pixel word");
`endif

endmodule

FILE: tb/sv/ppfc_conversion_checker.sv
// Watches the input, output and configuration ports of the converter, predicts
// each result from its own copy of the registers, and compares results in order.
module ppfc_conversion_checker
  import ppfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  ppfc_in_if                pix_in,
  ppfc_out_if               pix_out,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [63:0] word;
    comp4_t      comp;
  } pixel_res_t;

  cfg_t       cfg_shadow;
  pixel_res_t expected_px_q[$];
  int         mismatches;
  string      comp_name[4] = '{"red", "green", "blue", "alpha"};

  // Slot that component c occupies for a given channel order
  function automatic int unsigned slot_for(logic [1:0] order, int unsigned c);
    case (order)
      ORDER_RGBA: return c;
      ORDER_ARGB: return (c + 1) % 4;
      ORDER_BGRA: return (c == COMP_ALPHA) ? c : 2 - c;
      default:    return 3 - c;
    endcase
  endfunction

  // Extract one slot and widen it to UNORM16
  function automatic logic [15:0] slot_to_unorm(logic [1:0] layout, logic [63:0] word,
                                                int unsigned slot);
    int unsigned sh;
    int unsigned v;
    case (layout)
      LAYOUT_555: begin
        if (slot == 3) return 16'h0000;
        sh = 10 - 5 * slot;
        v  = 32'((word >> sh) & 64'h1f);
        return 16'((v * 65535 + 15) / 31);
      end
      LAYOUT_4444: begin
        sh = 4 * (3 - slot);
        v  = 32'((word >> sh) & 64'hf);
        return 16'(v * 4369);
      end
      LAYOUT_8: begin
        sh = 8 * slot;
        v  = 32'((word >> sh) & 64'hff);
        return 16'(v * 257);
      end
      default: begin
        sh = 16 * slot;
        return 16'((word >> sh) & 64'hffff);
      end
    endcase
  endfunction

  // Narrow a UNORM16 value into its slot; other bits kept, but 5-5-5 clears bit 15
  function automatic logic [63:0] unorm_to_slot(logic [1:0] layout, logic [63:0] word,
                                                int unsigned slot, logic [15:0] c);
    int unsigned sh;
    int unsigned q;
    case (layout)
      LAYOUT_555: begin
        if (slot == 3) return word;
        sh = 10 - 5 * slot;
        q  = (int'(c) * 31) / 65535;
        // field and the spare top bit are both cleared
        word &= ~((64'h1f << sh) | (64'h1 << 15));
        return word | (64'(q) << sh);
      end
      LAYOUT_4444: begin
        sh = 4 * (3 - slot);
        q  = int'(c) / 4369;
        word &= ~(64'hf << sh);
        return word | (64'(q) << sh);
      end
      LAYOUT_8: begin
        sh = 8 * slot;
        q  = int'(c) / 257;
        word &= ~(64'hff << sh);
        return word | (64'(q) << sh);
      end
      default: begin
        sh = 16 * slot;
        word &= ~(64'hffff << sh);
        return word | (64'(c) << sh);
      end
    endcase
  endfunction

  // Expected result of one input transfer
  function automatic pixel_res_t convert_pixel(cfg_t c, logic mode, logic [63:0] word,
                                               comp4_t comp_in);
    pixel_res_t  r;
    comp4_t      comp;
    int unsigned k;
    comp   = comp_in;
    r.word = word;
    r.comp = '0;
    if (mode == MODE_PACK) begin
      // zero alpha blanks the color, present or not
      if (comp[COMP_ALPHA] == 16'h0000) begin
        comp[0] = '0;
        comp[1] = '0;
        comp[2] = '0;
      end
      for (k = 0; k < 4; k++) begin
        if (c.present[k]) r.word = unorm_to_slot(c.layout, r.word, slot_for(c.order, k), comp[k]);
      end
    end else begin
      for (k = 0; k < 4; k++) begin
        if (c.present[k])
          r.comp[k] = slot_to_unorm(c.layout, word, slot_for(c.order, k));
        else
          r.comp[k] = (k == COMP_ALPHA) ? ALPHA_DEFAULT : COLOR_DEFAULT;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_res_t got;
    pixel_res_t want;
    comp4_t     comp_in;
    if (!rst_ni) begin
      cfg_shadow.layout  = LAYOUT_RST;
      cfg_shadow.order   = ORDER_RST;
      cfg_shadow.present = PRESENT_RST;
      expected_px_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (pix_out.valid && pix_out.ready) begin
        got.word = pix_out.pixel_out;
        got.comp = {pix_out.alpha_out, pix_out.blue_out, pix_out.green_out, pix_out.red_out};
        if (expected_px_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got.word);
          mismatches++;
        end else begin
          want = expected_px_q.pop_front();
          if (got.word !== want.word) begin
            $display("%0t: pixel_out mismatch expected %h got %h", $time, want.word, got.word);
            mismatches++;
          end
          for (int k = 0; k < 4; k++) begin
            if (got.comp[k] !== want.comp[k]) begin
              $display("%0t: %s_out mismatch expected %h got %h", $time, comp_name[k],
                       want.comp[k], got.comp[k]);
              mismatches++;
            end
          end
        end
      end
      // input transfer: predict with the registers as they stand
      if (pix_in.valid && pix_in.ready) begin
        comp_in = {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};
        expected_px_q.push_back(convert_pixel(cfg_shadow, pix_in.mode, pix_in.pixel_in,
                                              comp_in));
      end
      // register writes; unused index is ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LAYOUT:  cfg_shadow.layout  = cfg_data_i[1:0];
          CFG_ORDER:   cfg_shadow.order   = cfg_data_i[1:0];
          CFG_PRESENT: cfg_shadow.present = cfg_data_i[3:0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_px_q.size();
    end
  end

endmodule

FILE: tb/sv/packed_pixel_format_converter_unit_test.sv
module packed_pixel_format_converter_unit_test;
  import ppfc_pkg::*;

  localparam int         STALL_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 4;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  int                fail_count;
  int                pending;
  int                idle_cycles;
  bit                quiet;

  ppfc_in_if  pix_in ();
  ppfc_out_if pix_out ();

  packed_pixel_format_converter_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pix_in),
    .out_o      (pix_out)
  );

  ppfc_conversion_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pix_in       (pix_in),
    .pix_out      (pix_out),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none in quiet phases
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_unorm();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // One item: optional gap, then hold until the transfer
  task automatic push_pixel(logic mode, logic [63:0] word, logic [15:0] r, logic [15:0] g,
                            logic [15:0] b, logic [15:0] a);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.mode     <= mode;
    pix_in.pixel_in <= word;
    pix_in.red_in   <= r;
    pix_in.green_in <= g;
    pix_in.blue_in  <= b;
    pix_in.alpha_in <= a;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  task automatic push_random();
    logic [15:0] a;
    logic        mode;
    a    = ($urandom_range(0, 6) == 0) ? 16'h0000 : rand_unorm();
    mode = ($urandom_range(0, 1) == 0) ? MODE_UNPACK : MODE_PACK;
    push_pixel(mode, {$urandom, $urandom}, rand_unorm(), rand_unorm(), rand_unorm(), a);
  endtask

  // Stop sending and wait until every result has come back
  task automatic settle();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes
  task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Spare data bits above the 2-bit registers carry noise
  task automatic set_config(logic [1:0] layout, logic [1:0] order, logic [3:0] present);
    logic [CFG_DW-1:0] d;
    d = CFG_DW'($urandom);
    d[1:0] = layout;
    write_reg(CFG_LAYOUT, d);
    d = CFG_DW'($urandom);
    d[1:0] = order;
    write_reg(CFG_ORDER, d);
    write_reg(CFG_PRESENT, present);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: ready runs broken by random stalls
  initial begin
    int n;
    pix_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      pix_out.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      n = idle_len();
      if (n > 0) begin
        pix_out.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("packed_pixel_format_converter_unit verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    quiet           = 1'b0;
    idle_cycles     = 0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_LAYOUT;
    cfg_data_i      = '0;
    pix_in.valid    = 1'b0;
    pix_in.mode     = MODE_UNPACK;
    pix_in.pixel_in = '0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.alpha_in = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 8-bit, RGBA, all present
    push_pixel(MODE_UNPACK, 64'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    push_pixel(MODE_UNPACK, '1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_pixel(MODE_UNPACK, 64'h0123_4567_89ab_cdef, 16'h0, 16'h0, 16'h0, 16'h0);
    push_pixel(MODE_PACK, 64'h0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_pixel(MODE_PACK, '1, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    push_pixel(MODE_PACK, 64'h5a5a_a5a5_0ff0_f00f, 16'h8000, 16'h7fff, 16'h0101, 16'h0001);
    settle();

    // 5-5-5 with alpha absent; red lands in slot three
    set_config(LAYOUT_555, ORDER_ABGR, 4'b0111);
    push_pixel(MODE_PACK, '1, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    push_pixel(MODE_PACK, '1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_pixel(MODE_UNPACK, '1, 16'h0, 16'h0, 16'h0, 16'h0);
    settle();

    // 5-5-5 writing only slot three leaves the word untouched
    set_config(LAYOUT_555, ORDER_RGBA, 4'b1000);
    push_pixel(MODE_PACK, '1, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    push_pixel(MODE_UNPACK, 64'h0000_0000_0000_7fff, 16'h0, 16'h0, 16'h0, 16'h0);
    settle();

    set_config(LAYOUT_4444, ORDER_BGRA, 4'b1010);
    push_pixel(MODE_UNPACK, 64'hfedc_ba98_7654_3210, 16'h0, 16'h0, 16'h0, 16'h0);
    push_pixel(MODE_PACK, '1, 16'h1111, 16'h4368, 16'hfffe, 16'h4369);
    settle();

    set_config(LAYOUT_16, ORDER_ARGB, 4'b1111);
    push_pixel(MODE_UNPACK, 64'h0123_4567_89ab_cdef, 16'h0, 16'h0, 16'h0, 16'h0);
    push_pixel(MODE_PACK, 64'h0, 16'hffff, 16'h0001, 16'h8000, 16'h7fff);
    settle();

    // nothing present: defaults on unpack, word passed through on pack
    set_config(LAYOUT_16, ORDER_ABGR, 4'b0000);
    push_pixel(MODE_UNPACK, '1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_pixel(MODE_PACK, 64'hdead_beef_cafe_f00d, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    settle();

    set_config(LAYOUT_8, ORDER_ABGR, 4'b0101);
    push_pixel(MODE_PACK, 64'h1122_3344_5566_7788, 16'h00ff, 16'h0100, 16'hff00, 16'h0000);
    push_pixel(MODE_UNPACK, 64'h1122_3344_5566_7788, 16'h0, 16'h0, 16'h0, 16'h0);
    settle();

    // random phases, each under random settings; every fourth one without gaps
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) write_reg(CFG_UNUSED, CFG_DW'($urandom));
      set_config(2'($urandom), 2'($urandom), 4'($urandom));
      quiet = (ph % 4 == 3);
      for (int n = 0; n < 48; n++) push_random();
      settle();
      quiet = 1'b0;
    end

    if (fail_count == 0)
      $display("packed_pixel_format_converter_unit verification clean");
    else
      $display("packed_pixel_format_converter_unit verification failed");
    $finish;
  end

endmodule
